// File: rtl/core/whmf_pkg.sv
package whmf_pkg;

  localparam logic [31:0] HashInit = 32'hdeadbeef;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
  } hash_state_t;

  // completed key handed from the accumulator to the final stage
  typedef struct packed {
    logic        load;
    hash_state_t st;
  } fin_req_t;

  localparam hash_state_t StateInit = '{a: HashInit, b: HashInit, c: HashInit};

  function automatic logic [31:0] rotl(input logic [31:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (32 - n));
  endfunction

  function automatic hash_state_t mix_rounds(input hash_state_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = s.a;
    b = s.b;
    c = s.c;
    a = a - c; a = a ^ rotl(c, 4);  c = c + b;
    b = b - a; b = b ^ rotl(a, 6);  a = a + c;
    c = c - b; c = c ^ rotl(b, 8);  b = b + a;
    a = a - c; a = a ^ rotl(c, 16); c = c + b;
    b = b - a; b = b ^ rotl(a, 19); a = a + c;
    c = c - b; c = c ^ rotl(b, 4);  b = b + a;
    mix_rounds = '{a: a, b: b, c: c};
  endfunction

  function automatic hash_state_t final_rounds(input hash_state_t s);
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    a = s.a;
    b = s.b;
    c = s.c;
    c = c ^ b; c = c - rotl(b, 14);
    a = a ^ c; a = a - rotl(c, 11);
    b = b ^ a; b = b - rotl(a, 25);
    c = c ^ b; c = c - rotl(b, 16);
    a = a ^ c; a = a - rotl(c, 4);
    b = b ^ a; b = b - rotl(a, 14);
    c = c ^ b; c = c - rotl(b, 24);
    final_rounds = '{a: a, b: b, c: c};
  endfunction

endpackage

// File: rtl/core/word_hash_mix_final.sv
// Channel  Handshake              Payload
// in       in_valid / in_ready    key_word    (one 32-bit key word per transfer)
// out      out_valid / out_ready  hash_value  (one hash per completed key)
// cfg      cfg_valid / cfg_ready  key_words   (words per key, 0 means 256)
//
// One key word per cycle, but for the stall named below. A key's last
// word passes the input register, accumulate (mix rounds and add) into the
// final stage, then final rounds into the output register. The mix-and-add
// and the final-round paths are each about seven add levels deep and set
// the clock. Synchronous reset clears the accumulators to their initial
// value and sets key_len to 1. A stalled output backs up through the final
// stage only when a key's last word needs it; cfg_ready is always high.
module word_hash_mix_final (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] key_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] hash_value,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  key_words
);

  logic [7:0]         key_len;
  logic               fin_free;
  whmf_pkg::fin_req_t fin_req;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_len <= 8'd1;
    end else if (cfg_valid && cfg_ready) begin
      key_len <= key_words;
    end
  end

  whmf_accum u_accum (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .key_word (key_word),
    .key_len  (key_len),
    .fin_free (fin_free),
    .fin_req  (fin_req)
  );

  whmf_final u_final (
    .clk        (clk),
    .rst        (rst),
    .fin_req    (fin_req),
    .fin_free   (fin_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hash_value (hash_value)
  );

endmodule

// File: rtl/core/whmf_accum.sv
module whmf_accum (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [31:0]          key_word,
  input  logic [7:0]           key_len,
  input  logic                 fin_free,
  output whmf_pkg::fin_req_t   fin_req
);

  logic                  w_valid;
  logic [31:0]           w_word;
  whmf_pkg::hash_state_t acc;
  logic [1:0]            group_pos;
  logic [7:0]            words_taken;

  whmf_pkg::hash_state_t acc_next;
  logic [1:0]            group_pos_next;
  logic [7:0]            taken_next;
  logic                  w_last;
  logic                  w_go;

  assign taken_next = words_taken + 8'd1;
  assign w_last     = (taken_next == key_len);
  assign w_go       = w_valid && (!w_last || fin_free);
  assign in_ready   = !w_valid || w_go;

  always_comb begin
    acc_next       = acc;
    group_pos_next = group_pos;
    if (group_pos == 2'd3) begin
      acc_next       = whmf_pkg::mix_rounds(acc);
      group_pos_next = 2'd0;
    end
    unique case (group_pos_next)
      2'd0:    acc_next.a = acc_next.a + w_word;
      2'd1:    acc_next.b = acc_next.b + w_word;
      default: acc_next.c = acc_next.c + w_word;
    endcase
    group_pos_next = group_pos_next + 2'd1;
  end

  assign fin_req.load = w_go && w_last;
  assign fin_req.st   = acc_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      w_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      w_valid <= 1'b1;
    end else if (w_go) begin
      w_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      w_word <= key_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc         <= whmf_pkg::StateInit;
      group_pos   <= 2'd0;
      words_taken <= 8'd0;
    end else if (w_go) begin
      if (w_last) begin
        acc         <= whmf_pkg::StateInit;
        group_pos   <= 2'd0;
        words_taken <= 8'd0;
      end else begin
        acc         <= acc_next;
        group_pos   <= group_pos_next;
        words_taken <= taken_next;
      end
    end
  end

endmodule

// File: rtl/core/whmf_final.sv
module whmf_final (
  input  logic               clk,
  input  logic               rst,
  input  whmf_pkg::fin_req_t fin_req,
  output logic               fin_free,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        hash_value
);

  logic                  fin_valid;
  whmf_pkg::hash_state_t fin_st;
  whmf_pkg::hash_state_t fin_res;
  logic                  out_take;

  assign out_take = !out_valid || out_ready;
  assign fin_free = !fin_valid || out_take;
  assign fin_res  = whmf_pkg::final_rounds(fin_st);

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_req.load) begin
      fin_valid <= 1'b1;
    end else if (out_take) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_req.load) begin
      fin_st <= fin_req.st;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_valid && out_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && out_take) begin
      hash_value <= fin_res.c;
    end
  end

endmodule
